[rtl/gts_pkg.sv]
// Package for the greedy tardiness scheduler: sizes, job table entry type
// and the request that drives the shared cost unit. No dependencies.
package gts_pkg;

	localparam int MAX_JOBS = 16;

	// Table address and a count that can hold MAX_JOBS itself
	localparam int IDX_W = $clog2(MAX_JOBS);
	localparam int CNT_W = $clog2(MAX_JOBS + 1);

	// Field widths fixed by the interface
	localparam int VAL_W    = 16;
	localparam int JIDX_W   = 4;
	localparam int COUNT_W  = 5;
	localparam int OUT_W    = 40;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W    = 5;

	// Finish times never exceed (MAX_JOBS + 1) full durations
	localparam int TIME_W = VAL_W + $clog2(MAX_JOBS + 1);
	localparam int PROD_W = VAL_W + TIME_W;
	localparam int FRAC_W = 8;
	localparam int COST_W = PROD_W - FRAC_W + 1;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_JOB_COUNT = 1'd1;

	// Input operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_RUN  = 1'b1;

	typedef struct packed {
		logic [VAL_W-1:0] duration;
		logic [VAL_W-1:0] deadline;
		logic [VAL_W-1:0] penalty;
		logic [VAL_W-1:0] slope;
	} job_t;

	localparam int JOB_W = $bits(job_t);

	typedef struct packed {
		logic [TIME_W-1:0] finish;
		logic [VAL_W-1:0]  deadline;
		logic [VAL_W-1:0]  penalty;
		logic [VAL_W-1:0]  slope;
	} cost_req_t;

endpackage

[rtl/greedy_tardiness_scheduler.sv]
// Greedy weighted-tardiness scheduler top level: sequencer, job table RAM
// and shared cost unit. Depends on gts_pkg, gts_ram and gts_cost_unit.
//
// A load request writes one job entry and its placed bit. A run request
// first sweeps the n jobs in use (a read state, then an accumulate state,
// per job) to sum the placed durations and the final finish time, then
// makes one pick per pending job, or posts one empty result if none is
// pending. Each pick scans the table once: a job not pending takes only the
// read state; a pending job also takes the multiply and add states, twice in
// mode 1 (the single multiplier is used twice); then the result is posted.
// A result waits until the output register is free or being drained. Results
// wait in an output register, so a load may be taken while the last result
// of a run is still pending at the output.
module greedy_tardiness_scheduler
	import gts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 op,
	input  logic [JIDX_W-1:0]    job_index,
	input  logic [VAL_W-1:0]     duration,
	input  logic [VAL_W-1:0]     deadline,
	input  logic [VAL_W-1:0]     penalty,
	input  logic [VAL_W-1:0]     slope,
	input  logic                 scheduled,

	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [JIDX_W-1:0]    picked_job,
	output logic                 has_job,
	output logic [OUT_W-1:0]     job_cost,
	output logic [OUT_W-1:0]     total_cost,
	output logic                 last
);

	typedef enum logic [2:0] {
		IDLE,
		SUM_RD,
		SUM_ACC,
		SCAN_RD,
		SCAN_MUL,
		SCAN_ADD,
		EMIT
	} state_t;

	state_t state_q;

	logic                mode_q;
	logic [COUNT_W-1:0]  job_count_q;
	logic [MAX_JOBS-1:0] placed_q;
	logic [MAX_JOBS-1:0] pend_q;
	logic [CNT_W-1:0]    n_q;
	logic [CNT_W-1:0]    idx_q;
	logic [TIME_W-1:0]   now_q;
	logic [TIME_W-1:0]   tend_q;
	logic                phase_q;
	logic                found_q;
	logic                empty_q;
	logic [COST_W-1:0]   first_cost_q;
	logic [COST_W-1:0]   best_cost_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic [VAL_W-1:0]    best_dur_q;
	logic [OUT_W-1:0]    total_q;

	logic                in_fire;
	logic                emit_go;
	logic [IDX_W-1:0]    ld_idx;
	logic                ld_ok;
	logic                ram_we;
	job_t                ram_wdata;
	job_t                rd_job;
	logic [IDX_W-1:0]    rd_idx;
	logic [CNT_W-1:0]    n_run;
	logic [MAX_JOBS-1:0] pend_init;
	logic [MAX_JOBS-1:0] pend_left;
	logic                scan_end;
	cost_req_t           req;
	logic [COST_W-1:0]   cost;
	logic [COST_W:0]     avg_sum;
	logic [COST_W-1:0]   cand;
	logic [OUT_W:0]      total_sum;
	logic [OUT_W-1:0]    total_next;

	assign in_ready = (state_q == IDLE);
	assign in_fire  = in_valid && in_ready;

	// Post a result when the output register is free or being drained
	assign emit_go  = (state_q == EMIT) && (!out_valid || out_ready);

	assign ld_idx    = IDX_W'(job_index);
	assign ld_ok     = int'(job_index) < MAX_JOBS;
	assign ram_we    = in_fire && (op == OP_LOAD) && ld_ok;
	assign ram_wdata = '{duration: duration, deadline: deadline,
	                     penalty: penalty, slope: slope};
	assign rd_idx    = idx_q[IDX_W-1:0];

	gts_ram #(
		.WIDTH(JOB_W),
		.DEPTH(MAX_JOBS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ld_idx),
		.wdata(ram_wdata),
		.raddr(rd_idx),
		.rdata(rd_job)
	);

	// Finish if run next, or at the end of the whole schedule
	always_comb begin
		req.finish   = phase_q ? tend_q : now_q + TIME_W'(rd_job.duration);
		req.deadline = rd_job.deadline;
		req.penalty  = rd_job.penalty;
		req.slope    = rd_job.slope;
	end

	gts_cost_unit u_cost (
		.clk (clk),
		.req (req),
		.cost(cost)
	);

	always_comb begin
		if (int'(job_count_q) > MAX_JOBS) begin
			n_run = CNT_W'(MAX_JOBS);
		end else begin
			n_run = CNT_W'(job_count_q);
		end
		for (int i = 0; i < MAX_JOBS; i++) begin
			pend_init[i] = (CNT_W'(i) < n_run) && !placed_q[i];
		end
	end

	assign avg_sum  = (COST_W + 1)'(first_cost_q) + (COST_W + 1)'(cost);
	assign cand     = mode_q ? avg_sum[COST_W:1] : cost;
	assign scan_end = (idx_q + CNT_W'(1)) == n_q;

	always_comb begin
		pend_left             = pend_q;
		pend_left[best_idx_q] = 1'b0;
	end

	// Saturate the running total
	assign total_sum  = (OUT_W + 1)'(total_q) + (OUT_W + 1)'(best_cost_q);
	assign total_next = total_sum[OUT_W] ? '1 : total_sum[OUT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			mode_q       <= 1'b0;
			job_count_q  <= COUNT_W'(16);
			placed_q     <= '0;
			pend_q       <= '0;
			n_q          <= '0;
			idx_q        <= '0;
			now_q        <= '0;
			tend_q       <= '0;
			phase_q      <= 1'b0;
			found_q      <= 1'b0;
			empty_q      <= 1'b0;
			first_cost_q <= '0;
			best_cost_q  <= '0;
			best_idx_q   <= '0;
			best_dur_q   <= '0;
			total_q      <= '0;
			out_valid    <= 1'b0;
			picked_job   <= '0;
			has_job      <= 1'b0;
			job_cost     <= '0;
			total_cost   <= '0;
			last         <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE:      mode_q      <= cfg_data[0];
					REG_JOB_COUNT: job_count_q <= cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end

			if (emit_go) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end

			case (state_q)
				IDLE: begin
					if (in_fire) begin
						if (op == OP_LOAD) begin
							if (ld_ok) begin
								placed_q[ld_idx] <= scheduled;
							end
						end else begin
							n_q     <= n_run;
							pend_q  <= pend_init;
							idx_q   <= '0;
							now_q   <= '0;
							tend_q  <= '0;
							total_q <= '0;
							phase_q <= 1'b0;
							found_q <= 1'b0;
							empty_q <= (pend_init == '0);
							state_q <= (n_run == '0) ? EMIT : SUM_RD;
						end
					end
				end
				SUM_RD: begin
					state_q <= SUM_ACC;
				end
				SUM_ACC: begin
					tend_q <= tend_q + TIME_W'(rd_job.duration);
					if (placed_q[rd_idx]) begin
						now_q <= now_q + TIME_W'(rd_job.duration);
					end
					if (scan_end) begin
						idx_q   <= '0;
						state_q <= empty_q ? EMIT : SCAN_RD;
					end else begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= SUM_RD;
					end
				end
				SCAN_RD: begin
					phase_q <= 1'b0;
					if (pend_q[rd_idx]) begin
						state_q <= SCAN_MUL;
					end else if (scan_end) begin
						state_q <= EMIT;
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				SCAN_MUL: begin
					state_q <= SCAN_ADD;
				end
				SCAN_ADD: begin
					if (mode_q && !phase_q) begin
						// hold the next-finish cost, then cost at the final finish
						first_cost_q <= cost;
						phase_q      <= 1'b1;
						state_q      <= SCAN_MUL;
					end else begin
						if (!found_q || cand > best_cost_q) begin
							found_q     <= 1'b1;
							best_cost_q <= cand;
							best_idx_q  <= rd_idx;
							best_dur_q  <= rd_job.duration;
						end
						if (scan_end) begin
							state_q <= EMIT;
						end else begin
							idx_q   <= idx_q + CNT_W'(1);
							state_q <= SCAN_RD;
						end
					end
				end
				EMIT: begin
					if (emit_go) begin
						if (empty_q) begin
							picked_job <= '0;
							has_job    <= 1'b0;
							job_cost   <= '0;
							total_cost <= '0;
							last       <= 1'b1;
							state_q    <= IDLE;
						end else begin
							picked_job <= JIDX_W'(best_idx_q);
							has_job    <= 1'b1;
							job_cost   <= OUT_W'(best_cost_q);
							total_cost <= total_next;
							last       <= (pend_left == '0);
							total_q    <= total_next;
							pend_q     <= pend_left;
							now_q      <= now_q + TIME_W'(best_dur_q);
							found_q    <= 1'b0;
							idx_q      <= '0;
							state_q    <= (pend_left == '0) ? IDLE : SCAN_RD;
						end
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/gts_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/gts_cost_unit.sv]
// Shared lateness cost unit: registers slope * lateness, then forms
// penalty + product >> 8 (or zero when on time). Depends on gts_pkg.
module gts_cost_unit
	import gts_pkg::*;
(
	input  logic              clk,
	input  cost_req_t         req,
	output logic [COST_W-1:0] cost
);

	logic              late;
	logic [TIME_W-1:0] lateness;

	logic              late_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [VAL_W-1:0]  pen_s1;

	assign late     = req.finish > TIME_W'(req.deadline);
	assign lateness = req.finish - TIME_W'(req.deadline);

	always_ff @(posedge clk) begin
		late_s1 <= late;
		prod_s1 <= PROD_W'(req.slope) * PROD_W'(lateness);
		pen_s1  <= req.penalty;
	end

	always_comb begin
		if (late_s1) begin
			cost = COST_W'(pen_s1) + COST_W'(prod_s1 >> FRAC_W);
		end else begin
			cost = '0;
		end
	end

endmodule
